// ===== rtl/bct_pkg.sv =====
// ----------------------------------------------------------------------------
// bct_pkg: shared types and constants of the box clip triangle unit
// Holds the coordinate widths, the sequencer state type and the register indexes.
// ----------------------------------------------------------------------------
package bct_pkg;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned AXIS_W  = 48;
  localparam int unsigned COMP_W  = 16;
  localparam int unsigned HALF_W  = 23;
  localparam int unsigned TOL_W   = 8;
  localparam int unsigned DIST_W  = 56;
  localparam int unsigned T_W     = 17;
  localparam int unsigned MAX_RESULTS = 9;

  localparam logic [2:0] REG_AXIS_A   = 3'd0;
  localparam logic [2:0] REG_AXIS_B   = 3'd1;
  localparam logic [2:0] REG_AXIS_C   = 3'd2;
  localparam logic [2:0] REG_CENTER_X = 3'd3;
  localparam logic [2:0] REG_CENTER_Y = 3'd4;
  localparam logic [2:0] REG_CENTER_Z = 3'd5;
  localparam logic [2:0] REG_HALF     = 3'd6;
  localparam logic [2:0] REG_TOL      = 3'd7;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_LOAD  = 11'b00000000010,
    ST_DOT   = 11'b00000000100,
    ST_DIST  = 11'b00000001000,
    ST_WALK  = 11'b00000010000,
    ST_DIV   = 11'b00000100000,
    ST_LERP  = 11'b00001000000,
    ST_LSUM  = 11'b00010000000,
    ST_PASS  = 11'b00100000000,
    ST_EMIT  = 11'b01000000000,
    ST_WAIT  = 11'b10000000000
  } state_t;

endpackage

// ===== rtl/box_clip_triangle_unit.sv =====
// ----------------------------------------------------------------------------
// box_clip_triangle_unit: clip one triangle against an oriented box
// Sequenced Sutherland-Hodgman clipper with one shared multiplier and a
// bit-serial divider for the edge interpolation factor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (valid/ready): one item is a triangle, p0..p2 in Q16.8.
//   Output channel (valid/ready): one item per surviving polygon vertex, up to
//   nine; last_vertex marks the final one; a rejected triangle gives no item.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): write while idle.
// Sequencing:
//   ready is high only in the idle state. Each plane pass takes a set-up
//   step, a distance per vertex (three multiply-accumulate steps on the
//   shared 25x17 multiplier plus a compare), one walk step per vertex and
//   a step to close the pass; each crossing edge adds a bit-serial division
//   for t, one quotient bit per cycle, and the interpolation of each
//   coordinate. A new triangle is taken only once the previous one is
//   rejected or its last result is accepted, so the unit holds one
//   triangle at a time.
// Reset: synchronous rst restores the box to the unit cube of radius 8.0,
//   centred at the origin, tolerance 26, and drops any item in flight.
// Stall: a result item holds on the output until taken; the sequencer
//   waits and takes no new triangle meanwhile.
module box_clip_triangle_unit #(
  parameter int unsigned MAX_POLY_VERTS = 16,
  parameter int unsigned PLANE_COUNT    = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [23:0] p0_x, p0_y, p0_z,
  input  logic signed [23:0] p1_x, p1_y, p1_z,
  input  logic signed [23:0] p2_x, p2_y, p2_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [23:0] out_x, out_y, out_z,
  output logic        last_vertex,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int unsigned VI_W = $clog2(MAX_POLY_VERTS);
  localparam int unsigned CNT_W = $clog2(MAX_POLY_VERTS + 1);
  localparam int unsigned CW = bct_pkg::COORD_W;
  localparam int unsigned DW = bct_pkg::DIST_W;

  // configuration registers
  logic [47:0] axis_a, axis_b, axis_c;
  logic signed [CW-1:0] center_x, center_y, center_z;
  logic [bct_pkg::HALF_W-1:0] half_size;
  logic [bct_pkg::TOL_W-1:0] on_tolerance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_a <= 48'd16384;
      axis_b <= 48'd1073741824;
      axis_c <= 48'd70368744177664;
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
      half_size <= 23'd2048;
      on_tolerance <= 8'd26;
    end else if (cfg_valid) begin
      case (cfg_index)
        bct_pkg::REG_AXIS_A:   axis_a <= cfg_data;
        bct_pkg::REG_AXIS_B:   axis_b <= cfg_data;
        bct_pkg::REG_AXIS_C:   axis_c <= cfg_data;
        bct_pkg::REG_CENTER_X: center_x <= cfg_data[CW-1:0];
        bct_pkg::REG_CENTER_Y: center_y <= cfg_data[CW-1:0];
        bct_pkg::REG_CENTER_Z: center_z <= cfg_data[CW-1:0];
        bct_pkg::REG_HALF:     half_size <= cfg_data[bct_pkg::HALF_W-1:0];
        bct_pkg::REG_TOL:      on_tolerance <= cfg_data[bct_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // polygon stores: current and next, register arrays of small depth
  logic signed [CW-1:0] poly [MAX_POLY_VERTS][3];
  logic signed [CW-1:0] nxt  [MAX_POLY_VERTS][3];
  logic signed [DW-1:0] vdist [MAX_POLY_VERTS];
  logic [1:0]           side [MAX_POLY_VERTS];  // 01 front, 11 back, 00 on

  bct_pkg::state_t state;
  logic [2:0]      plane;
  logic [CNT_W-1:0] n, newc;
  logic [VI_W-1:0] vi;
  logic [1:0]      comp;
  logic            front;
  logic signed [DW-1:0] acc;

  // shared multiplier: 25-bit signed by 17-bit signed
  logic signed [CW:0]   mul_a;
  logic signed [16:0]   mul_b;
  logic signed [41:0]   mul_p;
  logic signed [41:0]   prod;
  assign mul_p = mul_a * mul_b;

  // divider state
  logic [DW:0]   a0, den;
  logic [DW+17:0] rem;
  logic [16:0]   quo;
  logic [4:0]    dcnt;
  logic [16:0]   t;

  // edge endpoint index
  logic [VI_W-1:0] vn;
  assign vn = (CNT_W'(vi) + 1'b1 == n) ? '0 : vi + 1'b1;

  // output buffer pointer
  logic [CNT_W-1:0] oi, ocnt;

  logic [47:0] axis_sel;
  always_comb begin
    case (plane[2:1])
      2'd0:    axis_sel = axis_a;
      2'd1:    axis_sel = axis_b;
      default: axis_sel = axis_c;
    endcase
  end

  logic signed [CW-1:0] ctr_sel;
  always_comb begin
    case (comp)
      2'd0:    ctr_sel = center_x;
      2'd1:    ctr_sel = center_y;
      default: ctr_sel = center_z;
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == bct_pkg::ST_DOT) begin
      mul_a = {poly[vi][comp][CW-1], poly[vi][comp]} - {ctr_sel[CW-1], ctr_sel};
      mul_b = {axis_sel[16*comp+15], axis_sel[16*comp +: 16]};
    end else begin
      mul_a = {poly[vn][comp][CW-1], poly[vn][comp]} -
              {poly[vi][comp][CW-1], poly[vi][comp]};
      mul_b = {1'b0, t[15:0]};
      if (t[16]) mul_b = 17'sd0;
    end
  end

  logic signed [DW-1:0] tolv, dfin;
  assign tolv = DW'({on_tolerance, 14'd0});
  assign dfin = (plane[0] ? -acc : acc) + DW'({half_size, 14'd0});

  logic sidx_cross;
  assign sidx_cross = (side[vi] != 2'b00) && (side[vn] != 2'b00) && (side[vi] != side[vn]);

  logic [DW-1:0] ad_i, ad_n;
  assign ad_i = vdist[vi][DW-1] ? DW'(-vdist[vi]) : DW'(vdist[vi]);
  assign ad_n = vdist[vn][DW-1] ? DW'(-vdist[vn]) : DW'(vdist[vn]);

  // rounded lerp term, half away from zero; t = 65536 handled as v1 - v0
  logic signed [41:0] pabs;
  logic signed [CW:0] q;
  always_comb begin
    pabs = prod[41] ? -prod : prod;
    if (t[16])
      q = {poly[vn][comp][CW-1], poly[vn][comp]} - {poly[vi][comp][CW-1], poly[vi][comp]};
    else begin
      q = (CW+1)'((pabs + 42'sd32768) >>> 16);
      if (prod[41]) q = -q;
    end
  end

  assign in_ready = (state == bct_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bct_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        bct_pkg::ST_IDLE: if (in_valid) begin
          poly[0][0] <= p0_x; poly[0][1] <= p0_y; poly[0][2] <= p0_z;
          poly[1][0] <= p1_x; poly[1][1] <= p1_y; poly[1][2] <= p1_z;
          poly[2][0] <= p2_x; poly[2][1] <= p2_y; poly[2][2] <= p2_z;
          n <= CNT_W'(3);
          plane <= '0;
          state <= bct_pkg::ST_LOAD;
        end
        bct_pkg::ST_LOAD: begin
          // start a plane pass
          vi <= '0; comp <= '0; acc <= '0; front <= 1'b0;
          state <= bct_pkg::ST_DOT;
        end
        bct_pkg::ST_DOT: begin
          acc <= acc + DW'(mul_p);
          if (comp == 2'd2) state <= bct_pkg::ST_DIST;
          else comp <= comp + 1'b1;
        end
        bct_pkg::ST_DIST: begin
          vdist[vi] <= dfin;
          if (dfin > tolv) begin
            side[vi] <= 2'b01; front <= 1'b1;
          end else if (dfin < -tolv) side[vi] <= 2'b11;
          else side[vi] <= 2'b00;
          acc <= '0; comp <= '0;
          if (CNT_W'(vi) + 1'b1 == n) begin
            vi <= '0; newc <= '0;
            state <= bct_pkg::ST_WALK;
          end else begin
            vi <= vi + 1'b1;
            state <= bct_pkg::ST_DOT;
          end
        end
        bct_pkg::ST_WALK: begin
          if (!front) state <= bct_pkg::ST_IDLE;  // rejected: drop the item
          else begin
            if (side[vi] != 2'b11 && newc < CNT_W'(MAX_POLY_VERTS)) begin
              nxt[newc[VI_W-1:0]][0] <= poly[vi][0];
              nxt[newc[VI_W-1:0]][1] <= poly[vi][1];
              nxt[newc[VI_W-1:0]][2] <= poly[vi][2];
              newc <= newc + 1'b1;
            end
            if (sidx_cross) begin
              a0 <= {1'b0, ad_i};
              den <= {1'b0, ad_i} + {1'b0, ad_n};
              rem <= '0; quo <= '0; dcnt <= '0;
              state <= bct_pkg::ST_DIV;
            end else if (CNT_W'(vi) + 1'b1 == n) state <= bct_pkg::ST_PASS;
            else vi <= vi + 1'b1;
          end
        end
        bct_pkg::ST_DIV: begin
          // restoring division of (a0<<16 + den/2) by den, one bit a cycle
          if (dcnt == 5'd0) begin
            rem <= (DW+18)'({a0, 16'd0}) + (DW+18)'(den >> 1);
            dcnt <= 5'd1;
          end else begin
            if ((rem >> (17 - dcnt)) >= (DW+18)'(den)) begin
              rem <= rem - ((DW+18)'(den) << (17 - dcnt));
              quo <= quo | (17'd1 << (17 - dcnt));
            end
            if (dcnt == 5'd18) begin
              comp <= '0;
              state <= bct_pkg::ST_LERP;
            end else dcnt <= dcnt + 1'b1;
          end
        end
        bct_pkg::ST_LERP: begin
          t <= quo;
          if (dcnt == 5'd18) dcnt <= 5'd19;
          else begin
            prod <= mul_p;
            state <= bct_pkg::ST_LSUM;
          end
        end
        bct_pkg::ST_LSUM: begin
          if (newc < CNT_W'(MAX_POLY_VERTS))
            nxt[newc[VI_W-1:0]][comp] <= CW'({poly[vi][comp][CW-1], poly[vi][comp]} + q);
          if (comp == 2'd2) begin
            if (newc < CNT_W'(MAX_POLY_VERTS)) newc <= newc + 1'b1;
            if (CNT_W'(vi) + 1'b1 == n) state <= bct_pkg::ST_PASS;
            else begin
              vi <= vi + 1'b1;
              state <= bct_pkg::ST_WALK;
            end
          end else begin
            comp <= comp + 1'b1;
            state <= bct_pkg::ST_LERP;
          end
        end
        bct_pkg::ST_PASS: begin
          for (int i = 0; i < MAX_POLY_VERTS; i++)
            for (int k = 0; k < 3; k++) poly[i][k] <= nxt[i][k];
          n <= newc;
          if (plane + 1'b1 == 3'(PLANE_COUNT) || plane == 3'd5) begin
            if (newc < CNT_W'(3)) state <= bct_pkg::ST_IDLE;
            else begin
              ocnt <= (newc > CNT_W'(bct_pkg::MAX_RESULTS)) ?
                      CNT_W'(bct_pkg::MAX_RESULTS) : newc;
              oi <= '0;
              state <= bct_pkg::ST_EMIT;
            end
          end else begin
            plane <= plane + 1'b1;
            state <= bct_pkg::ST_LOAD;
          end
        end
        bct_pkg::ST_EMIT: begin
          out_x <= poly[oi[VI_W-1:0]][0];
          out_y <= poly[oi[VI_W-1:0]][1];
          out_z <= poly[oi[VI_W-1:0]][2];
          last_vertex <= (oi + 1'b1 == ocnt);
          out_valid <= 1'b1;
          state <= bct_pkg::ST_WAIT;
        end
        bct_pkg::ST_WAIT: if (out_ready) begin
          out_valid <= 1'b0;
          if (oi + 1'b1 == ocnt) state <= bct_pkg::ST_IDLE;
          else begin
            oi <= oi + 1'b1;
            state <= bct_pkg::ST_EMIT;
          end
        end
        default: state <= bct_pkg::ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/bct_checker.sv =====
// ----------------------------------------------------------------------------
// bct_checker: port-level checks of the box clip triangle unit
// Watches the handshakes and the framing of result items.
// ----------------------------------------------------------------------------
module bct_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_x,
  input logic        last_vertex
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(last_vertex))
    else $error("result item changed while stalled");

  // no new triangle while a result is pending
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready with a result pending");

  // a result never follows directly on acceptance
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid && !in_ready)
    else $error("block not busy after taking a triangle");

endmodule

bind box_clip_triangle_unit bct_checker u_bct_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_x(out_x),
  .last_vertex(last_vertex)
);
